@@ hdl/hhe_pkg.sv @@
// ----------------------------------------------------------------------------
// hhe_pkg
// Shared types, constants and the static Huffman code tables for the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hhe_pkg;

    localparam int CODE_W  = 30;   // widest code
    localparam int LEN_W   = 5;    // code length field
    localparam int BYTE_W  = 8;
    localparam int BUF_W   = 40;   // holds up to 7 pending bits plus a 30-bit code
    localparam int CNT_W   = 6;    // pending bit count, up to 37
    localparam int QDEPTH_DEF = 2;

    // One queued code, as handed from the front end to the bit packer
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              last;
    } t_entry;

    localparam logic [CODE_W-1:0] CODE_ROM [256] = '{
        30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3, 30'hfffffe4, 30'hfffffe5,
        30'hfffffe6, 30'hfffffe7,
        30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9, 30'hfffffea, 30'h3ffffffd,
        30'hfffffeb, 30'hfffffec,
        30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0, 30'hffffff1, 30'hffffff2,
        30'h3ffffffe, 30'hffffff3,
        30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7, 30'hffffff8, 30'hffffff9,
        30'hffffffa, 30'hffffffb,
        30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
        30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
        30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
        30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
        30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
        30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
        30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
        30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
        30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
        30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
        30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
        30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
        30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8, 30'h3fffd3, 30'h3fffd4, 30'h3fffd5,
        30'h7fffd9,
        30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc, 30'h7fffdd, 30'h7fffde,
        30'hffffeb, 30'h7fffdf,
        30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0, 30'hffffee, 30'h7fffe1,
        30'h7fffe2, 30'h7fffe3,
        30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5, 30'h3fffd9, 30'h7fffe6,
        30'h7fffe7, 30'hffffef,
        30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb, 30'h3fffdc, 30'h7fffe8,
        30'h7fffe9, 30'h1fffde,
        30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0, 30'h1fffdf, 30'h3fffdf,
        30'h7fffeb, 30'h7fffec,
        30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2, 30'h7fffed, 30'h3fffe1,
        30'h7fffee, 30'h7fffef,
        30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4, 30'h7ffff0, 30'h3fffe5,
        30'h3fffe6, 30'h7ffff1,
        30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1, 30'h3fffe7, 30'h7ffff2,
        30'h3fffe8, 30'h1ffffec,
        30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde, 30'h7ffffdf, 30'h3ffffe5,
        30'hfffff1, 30'h1ffffed,
        30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0, 30'h7ffffe1, 30'h3ffffe7,
        30'h7ffffe2, 30'hfffff2,
        30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9, 30'hffffffd, 30'h7ffffe3,
        30'h7ffffe4, 30'h7ffffe5,
        30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6, 30'h3fffe9, 30'h1fffe7,
        30'h1fffe8, 30'h7ffff3,
        30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef, 30'hfffff4, 30'hfffff5,
        30'h3ffffea, 30'h7ffff4,
        30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed, 30'h7ffffe7, 30'h7ffffe8,
        30'h7ffffe9, 30'h7ffffea,
        30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed, 30'h7ffffee, 30'h7ffffef,
        30'h7fffff0, 30'h3ffffee
    };

    localparam logic [LEN_W-1:0] LEN_ROM [256] = '{
        5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
        5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
        5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
        5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
        5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
        5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
        5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
        5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
        5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
        5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
        5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
        5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
        5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
        5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
        5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
        5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
        5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
        5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
        5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
        5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
        5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
        5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
        5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
        5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
        5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
        5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
        5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
        5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
        5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
        5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
    };

endpackage

`default_nettype wire

@@ hdl/hhe_front.sv @@
// ----------------------------------------------------------------------------
// hhe_front
// Looks up each input byte in the code table and queues code, length and the
// end-of-string flag for the bit packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hhe_front #(
    parameter int QDEPTH = hhe_pkg::QDEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic [7:0]     i_symbol,
    input  wire logic           i_end_of_string,
    output logic                o_q_valid,
    output hhe_pkg::t_entry     o_q_entry,
    input  wire logic           i_q_pop
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    hhe_pkg::t_entry   r_q [QDEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    hhe_pkg::t_entry   w_entry;
    logic              w_push;

    // Table lookup for the incoming byte
    always_comb begin
        w_entry.code = hhe_pkg::CODE_ROM[i_symbol];
        w_entry.len  = hhe_pkg::LEN_ROM[i_symbol];
        w_entry.last = i_end_of_string;
    end

    assign o_stall   = (r_count == CNT_FULL);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_count != '0);
    assign o_q_entry = r_q[r_rd_ptr];

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !i_q_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && i_q_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/hhe_back.sv @@
// ----------------------------------------------------------------------------
// hhe_back
// Bit packer: merges queued codes behind the pending bits and emits one
// output byte per cycle while the output is not stalled, through an output
// register, padding with ones at the end of a string.
// ----------------------------------------------------------------------------
`default_nettype none

module hhe_back (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    input  hhe_pkg::t_entry i_q_entry,
    output logic            o_q_pop,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_item,
    output logic            o_string_done
);

    localparam int BUF_W = hhe_pkg::BUF_W;
    localparam int CNT_W = hhe_pkg::CNT_W;
    localparam int CODE_W = hhe_pkg::CODE_W;
    localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(hhe_pkg::BYTE_W);

    logic [BUF_W-1:0] r_buf, n_buf;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_olast, r_odone;

    logic             w_full_byte, w_pad, w_work, w_slot, w_emit, w_final;
    logic [CNT_W-1:0] w_rem;
    logic [CODE_W-1:0] w_code_la;
    logic [BUF_W-1:0] w_ins;
    logic [7:0]       w_byte;

    // Classify what the pending bits allow
    assign w_full_byte = (r_cnt >= BYTE_BITS);
    assign w_pad       = !w_full_byte && r_last && (r_cnt != '0);
    assign w_work      = w_full_byte || w_pad;
    assign w_slot      = !r_ovalid || !i_stall;
    assign w_emit      = w_work && w_slot;
    assign o_q_pop     = !w_work && i_q_valid;
    assign w_rem       = r_cnt - BYTE_BITS;
    assign w_final     = w_pad || ((w_rem < BYTE_BITS) && !(r_last && (w_rem != '0)));
    assign w_byte      = w_pad ? (r_buf[BUF_W-1 -: 8] | (8'hff >> r_cnt[2:0]))
                               : r_buf[BUF_W-1 -: 8];

    // Left-align the new code behind the pending bits
    assign w_code_la = i_q_entry.code << (5'(CODE_W) - i_q_entry.len);
    assign w_ins     = {w_code_la, {(BUF_W-CODE_W){1'b0}}} >> r_cnt[2:0];

    // Next packer state
    always_comb begin
        n_buf  = r_buf;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (o_q_pop) begin
            n_buf  = r_buf | w_ins;
            n_cnt  = r_cnt + CNT_W'(i_q_entry.len);
            n_last = i_q_entry.last;
        end else if (w_emit) begin
            if (w_pad || (w_final && r_last)) begin
                n_buf  = '0;
                n_cnt  = '0;
                n_last = 1'b0;
            end else begin
                n_buf = r_buf << 8;
                n_cnt = w_rem;
            end
        end
    end

    // Hold packer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf  <= '0;
            r_cnt  <= '0;
            r_last <= 1'b0;
        end else begin
            r_buf  <= n_buf;
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_slot) begin
            r_ovalid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obyte <= w_byte;
            r_olast <= w_final;
            r_odone <= w_final && r_last;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_last_of_item = r_olast;
    assign o_string_done  = r_odone;

endmodule

`default_nettype wire

@@ hdl/hpack_huffman_encoder.sv @@
// ----------------------------------------------------------------------------
// hpack_huffman_encoder
// Static-table Huffman encoder for header strings, one input byte per
// transaction, coded bytes out one per transaction.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_symbol, i_end_of_string
//  output  | out       | o_valid / i_stall  | o_out_byte, o_last_of_item, o_string_done
//
//  A transaction is queued in the front-end FIFO; the packer loads its code
//  and then emits its output bytes, up to five per transaction.
//  The packer, at one byte per cycle unless stalled, sets the throughput.
//  Reset is synchronous, active low; it empties the queue and pending bits.
//  Output stall holds the output register; the queue absorbs QDEPTH inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module hpack_huffman_encoder #(
    parameter int QDEPTH = hhe_pkg::QDEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_symbol,
    input  wire logic       i_end_of_string,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_item,
    output logic            o_string_done
);

    logic            w_q_valid, w_q_pop;
    hhe_pkg::t_entry w_q_entry;

    hhe_front #(.QDEPTH(QDEPTH)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_symbol        (i_symbol),
        .i_end_of_string (i_end_of_string),
        .o_q_valid       (w_q_valid),
        .o_q_entry       (w_q_entry),
        .i_q_pop         (w_q_pop)
    );

    hhe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_entry      (w_q_entry),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_string_done  (o_string_done)
    );

    // The end of a string always closes its transaction
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_string_done) |-> o_last_of_item)
        else $error("string_done without last_of_item");

    // Pops only happen with data queued
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HPACK Huffman encoder: directed rows, then
// random strings, with every coded byte compared against an internal encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [7:0] sym;
        logic       eos;
        int         n_exp;      // -1: predictor only
        logic [7:0] b0;         // typed first byte when n_exp = 1
    } t_row;

    typedef struct {
        logic [7:0] byte_val;
        logic       last_item;
        logic       done;
    } t_coded;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_symbol = '0;
    logic       i_end_of_string = 1'b0;
    logic       i_stall = 1'b0;
    logic       o_stall, o_valid, o_last_of_item, o_string_done;
    logic [7:0] o_out_byte;

    t_coded     coded_q[$];
    logic [7:0] pend_bits = '0;
    int         pend_cnt = 0;
    int         errors = 0;
    int         cycles = 0;
    int         send_idle_pct = 15;
    int         recv_idle_pct = 72;
    int         limit = 400000;

    hpack_huffman_encoder uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Encode one symbol into the expected byte queue
    task automatic encode_symbol(input logic [7:0] sym, input logic eos);
        logic [63:0] acc;
        int          n;
        int          cnt;
        int          len;
        t_coded      c;
        len = int'(hhe_pkg::LEN_ROM[sym]);
        acc = (pend_cnt == 0) ? 64'd0 : (64'(pend_bits) >> (8 - pend_cnt));
        acc = (acc << len) | 64'(hhe_pkg::CODE_ROM[sym]);
        n = pend_cnt + len;
        cnt = 0;
        while (n >= 8) begin
            n -= 8;
            c.byte_val = acc[n +: 8];
            c.last_item = 1'b0;
            c.done = 1'b0;
            coded_q = {coded_q, c};
            cnt++;
        end
        pend_bits = (n == 0) ? 8'd0 : 8'((acc & ((64'd1 << n) - 1)) << (8 - n));
        pend_cnt = n;
        if (eos) begin
            if (n > 0) begin
                c.byte_val = pend_bits | (8'hff >> n);
                c.last_item = 1'b0;
                c.done = 1'b0;
                coded_q = {coded_q, c};
                cnt++;
            end
            pend_bits = '0;
            pend_cnt = 0;
        end
        if (cnt > 0) begin
            coded_q[$].last_item = 1'b1;
            coded_q[$].done = eos;
        end
    endtask

    // Drive one transaction and wait for its acceptance
    task automatic send(input logic [7:0] sym, input logic eos);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_symbol <= sym;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        encode_symbol(sym, eos);
    endtask

    // Drop valid and wait until every expected byte has come out
    task automatic drain();
        i_valid <= 1'b0;
        while (coded_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // Random receiver stall
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each accepted output transaction
    always @(posedge i_clk) begin
        t_coded e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (coded_q.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %h", $time, o_out_byte);
                errors++;
            end else begin
                e = coded_q.pop_front();
                if (e.byte_val !== o_out_byte || e.last_item !== o_last_of_item
                        || e.done !== o_string_done) begin
                    $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                             e.byte_val, e.last_item, e.done,
                             o_out_byte, o_last_of_item, o_string_done);
                    errors++;
                end
            end
        end
        if (cycles > limit) begin
            $display("simulation failed");
            $finish;
        end
    end

    t_row rows[] = '{
        '{8'h30, 1'b1, 1, 8'h07},   // shortest code, padded
        '{8'h61, 1'b1, 1, 8'h1f},
        '{8'h26, 1'b1, 1, 8'hf8},   // exact 8-bit fill at end, no padding
        '{8'h00, 1'b0, -1, 8'h0},
        '{8'h0a, 1'b0, -1, 8'h0},   // 30-bit code
        '{8'h0d, 1'b0, -1, 8'h0},
        '{8'h16, 1'b1, -1, 8'h0},
        '{8'h30, 1'b0, -1, 8'h0},   // no byte completed
        '{8'h31, 1'b0, -1, 8'h0},
        '{8'h32, 1'b0, -1, 8'h0},
        '{8'hff, 1'b1, -1, 8'h0},
        '{8'h7f, 1'b0, -1, 8'h0},
        '{8'h80, 1'b0, -1, 8'h0},
        '{8'h55, 1'b0, -1, 8'h0},
        '{8'haa, 1'b1, -1, 8'h0},
        '{8'h0f, 1'b0, -1, 8'h0},
        '{8'hf0, 1'b1, -1, 8'h0},
        '{8'hfe, 1'b1, -1, 8'h0}
    };

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; typed rows checked here against the predicted bytes
        foreach (rows[idx]) begin
            if (rows[idx].n_exp == 1) begin
                drain();
                send(rows[idx].sym, rows[idx].eos);
                if (coded_q.size() != 1 || coded_q[0].byte_val !== rows[idx].b0) begin
                    $display("%0t: table row %0d expected %h actual %h", $time, idx,
                             rows[idx].b0, coded_q.size() ? coded_q[0].byte_val : 8'hxx);
                    errors++;
                end
            end else begin
                send(rows[idx].sym, rows[idx].eos);
            end
        end
        i_valid <= 1'b0;
        // Hold off until the block is fully drained
        drain();

        // Random strings over three idle profiles
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 72 : 0;
            recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 15 : 0;
            for (int s = 0; s < 13; s++) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    // mostly printable text, some full-range bytes
                    send(($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 126)),
                         k == len - 1);
                end
            end
        end
        i_valid <= 1'b0;
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && coded_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
